>>> src/tasg_pkg.sv
// ============================================================================
// tasg_pkg
// Shared types, constants and tables of the thick arc strip generator.
// ============================================================================
`default_nettype none

package tasg_pkg;

   localparam int MAX_STEPS_DEF = 31;

   // radians (Q8.24) to phase units (2^32 per turn), scaled by 2^24
   localparam logic signed [32:0] PHASE_PER_RAD = 33'sd683565276;

   localparam int PROD_W = 66;

   // Q30 one
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // divider runs one quotient bit per cycle
   localparam logic [5:0] DIV_LAST = 6'd63;

   // highest Horner coefficient below the seed
   localparam logic [2:0] HORNER_TOP = 3'd4;
   localparam logic [2:0] HORNER_SEED = 3'd5;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_B,
      OP_DIVINIT,
      OP_DIV,
      OP_DIVEND,
      OP_ANGLE,
      OP_PHASE,
      OP_XLAT,
      OP_ARGB,
      OP_SQ,
      OP_X2,
      OP_HMUL,
      OP_HSUB,
      OP_FMUL,
      OP_SAVE,
      OP_TRIG,
      OP_PMX,
      OP_PX,
      OP_PMY,
      OP_PY,
      OP_EMIT,
      OP_NEXT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BMUL,
      ST_DIVINIT,
      ST_DIV,
      ST_DIVEND,
      ST_CHECK,
      ST_PHASE,
      ST_XLAT,
      ST_ARGB,
      ST_SQ,
      ST_X2,
      ST_HMUL,
      ST_HSUB,
      ST_FMUL,
      ST_SAVE,
      ST_TRIG,
      ST_PMX,
      ST_PX,
      ST_PMY,
      ST_PY,
      ST_EMIT,
      ST_NEXT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] coef_idx;
      logic       half_b;
      logic       outer;
      logic       end_pair;
      logic       req_ready;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic more_pairs;
      logic out_free;
   } status_type;

   // quarter-wave sine polynomial, Q30
   function automatic logic [31:0] sin_coef(input logic [2:0] idx);
      logic [31:0] c;
      begin
         unique case (idx)
            3'd0:    c = 32'd1686629713;
            3'd1:    c = 32'd693598669;
            3'd2:    c = 32'd85569298;
            3'd3:    c = 32'd5026995;
            3'd4:    c = 32'd172271;
            3'd5:    c = 32'd3864;
            default: c = 32'd0;
         endcase
         return c;
      end
   endfunction

endpackage

`default_nettype wire

>>> src/tasg_req_if.sv
// ============================================================================
// tasg_req_if
// Arc request channel: valid/ready handshake with the arc description.
// ============================================================================
`default_nettype none

interface tasg_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic        [30:0] radius;
   logic        [30:0] half_thickness;
   logic signed [31:0] angle_begin;
   logic signed [31:0] angle_end;
   logic signed [31:0] shade_begin;
   logic signed [31:0] shade_end;
   logic        [30:0] angle_step;

   modport source (
      output valid, center_x, center_y, radius, half_thickness,
             angle_begin, angle_end, shade_begin, shade_end, angle_step,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, radius, half_thickness,
             angle_begin, angle_end, shade_begin, shade_end, angle_step,
      output ready
   );
endinterface

`default_nettype wire

>>> src/tasg_rsp_if.sv
// ============================================================================
// tasg_rsp_if
// Vertex channel: valid/ready handshake with one strip vertex.
// ============================================================================
`default_nettype none

interface tasg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] across_x;
   logic signed [15:0] across_y;
   logic signed [15:0] along_x;
   logic signed [15:0] along_y;
   logic               side_positive;
   logic signed [31:0] shade;
   logic               last;

   modport source (
      output valid, pos_x, pos_y, across_x, across_y, along_x, along_y,
             side_positive, shade, last,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, across_x, across_y, along_x, along_y,
             side_positive, shade, last,
      output ready
   );
endinterface

`default_nettype wire

>>> src/tasg_datapath.sv
// ============================================================================
// tasg_datapath
// Shared multiplier, shade divider, sine evaluation and vertex register.
// ============================================================================
`default_nettype none

module tasg_datapath
   import tasg_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output status_type   status,
   tasg_req_if.sink     req_bus,
   tasg_rsp_if.source   rsp_bus
);

   localparam int CNT_W   = $clog2(MAX_STEPS + 1);
   localparam int OFF_W   = 31 + CNT_W;
   localparam int CMP_W   = (OFF_W > 33) ? OFF_W : 33;
   localparam int BSTEP_W = 35;
   localparam int SH_W    = BSTEP_W + CNT_W + 1;

   // request fields after ordering
   logic signed [31:0] cx_ff, cy_ff, a0_ff, a1_ff, b0_ff, b1_ff;
   logic signed [32:0] rin_ff, rout_ff;
   logic        [30:0] step_ff;
   logic        [32:0] span_ff;
   logic               rev_ff;

   // multiplier
   logic signed [32:0]       mul_a, mul_b;
   logic                     mul_en;
   logic signed [PROD_W-1:0] prod_ff;

   // shade step divider
   logic                      bneg_ff;
   logic        [63:0]        dq_ff;
   logic        [32:0]        rem_ff;
   logic signed [BSTEP_W-1:0] bstep_ff;

   // pair walk
   logic [CNT_W-1:0]       k_ff;
   logic [OFF_W-1:0]       off_ff;
   logic signed [SH_W-1:0] shacc_ff;

   // sine / cosine
   logic signed [31:0] ang_ff;
   logic [1:0]         quad_ff;
   logic [29:0]        x_ff;
   logic [30:0]        arg_ff, x2_ff;
   logic [31:0]        p_ff, sa_ff, sb_ff;
   logic signed [32:0] sin_ff, cos_ff;
   logic [14:0]        s15_ff, c15_ff;
   logic               sneg_ff, cneg_ff;
   logic signed [31:0] px_ff, py_ff;

   // output register
   logic               ovalid_ff;
   logic signed [31:0] opx_ff, opy_ff, oshade_ff;
   logic signed [15:0] oacx_ff, oacy_ff, oalx_ff, oaly_ff;
   logic               oside_ff, olast_ff;

   // load-time ordering
   logic               ld_rev;
   logic signed [31:0] ld_a0, ld_a1, ld_b0, ld_b1;
   logic signed [32:0] bdiff;
   logic [33:0]        div_shift;
   logic [34:0]        div_trial;
   logic [63:0]        prod_mag;
   logic [BSTEP_W-1:0] qt;
   logic [31:0]        smag, cmag;
   logic signed [31:0] sh_sat;
   logic               ovalid_in;

   function automatic logic signed [31:0] pos_sat(input logic signed [PROD_W-1:0] pr,
                                                  input logic signed [31:0] c);
      logic signed [PROD_W-1:0] t;
      logic signed [PROD_W-1:0] sh;
      logic signed [35:0]       sum;
      logic signed [31:0]       r;
      begin
         t   = pr + $signed(PROD_W'(64'h2000_0000));
         sh  = t >>> 30;
         sum = {{4{c[31]}}, c} + sh[35:0];
         if (sum > $signed(36'h0_7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
         else if (sum < $signed(36'hF_8000_0000))
            r = 32'sh8000_0000;
         else
            r = sum[31:0];
         return r;
      end
   endfunction

   function automatic logic [14:0] to_q15(input logic [31:0] m);
      logic [32:0] t;
      logic [14:0] r;
      begin
         t = {1'b0, m} + 33'd16384;
         if (t[32:15] > 18'd32767)
            r = 15'h7FFF;
         else
            r = t[29:15];
         return r;
      end
   endfunction

   function automatic logic signed [15:0] signed16(input logic neg, input logic [14:0] m);
      logic signed [15:0] r;
      begin
         r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
         return r;
      end
   endfunction

   assign ld_rev = req_bus.angle_begin > req_bus.angle_end;
   assign ld_a0  = ld_rev ? req_bus.angle_end : req_bus.angle_begin;
   assign ld_a1  = ld_rev ? req_bus.angle_begin : req_bus.angle_end;
   assign ld_b0  = ld_rev ? req_bus.shade_end : req_bus.shade_begin;
   assign ld_b1  = ld_rev ? req_bus.shade_begin : req_bus.shade_end;

   assign bdiff     = {b1_ff[31], b1_ff} - {b0_ff[31], b0_ff};
   assign div_shift = {rem_ff, dq_ff[63]};
   assign div_trial = {1'b0, div_shift} - {2'b00, span_ff};
   assign prod_mag  = prod_ff[PROD_W-1] ? 64'(-prod_ff) : prod_ff[63:0];
   assign qt        = dq_ff[BSTEP_W-1:0];
   assign smag      = quad_ff[0] ? sb_ff : sa_ff;
   assign cmag      = quad_ff[0] ? sa_ff : sb_ff;

   always_comb begin
      if (shacc_ff > $signed(SH_W'(32'h7FFF_FFFF)))
         sh_sat = 32'sh7FFF_FFFF;
      else if (shacc_ff < -$signed(SH_W'(33'h0_8000_0000)))
         sh_sat = 32'sh8000_0000;
      else
         sh_sat = shacc_ff[31:0];
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.op)
         OP_MUL_B: begin
            mul_a = bdiff;
            mul_b = $signed({2'b00, step_ff});
         end
         OP_PHASE: begin
            mul_a = {ang_ff[31], ang_ff};
            mul_b = PHASE_PER_RAD;
         end
         OP_SQ: begin
            mul_a = $signed({2'b00, arg_ff});
            mul_b = $signed({2'b00, arg_ff});
         end
         OP_HMUL: begin
            mul_a = $signed({1'b0, p_ff});
            mul_b = $signed({2'b00, x2_ff});
         end
         OP_FMUL: begin
            mul_a = $signed({1'b0, p_ff});
            mul_b = $signed({2'b00, arg_ff});
         end
         OP_PMX: begin
            mul_a = cmd.outer ? rout_ff : rin_ff;
            mul_b = cos_ff;
         end
         OP_PMY: begin
            mul_a = cmd.outer ? rout_ff : rin_ff;
            mul_b = sin_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en)
         prod_ff <= mul_a * mul_b;
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            rev_ff  <= ld_rev;
            cx_ff   <= req_bus.center_x;
            cy_ff   <= req_bus.center_y;
            a0_ff   <= ld_a0;
            a1_ff   <= ld_a1;
            b0_ff   <= ld_b0;
            b1_ff   <= ld_b1;
            rin_ff  <= {2'b00, req_bus.radius} - {2'b00, req_bus.half_thickness};
            rout_ff <= {2'b00, req_bus.radius} + {2'b00, req_bus.half_thickness};
            step_ff <= (req_bus.angle_step == '0) ? 31'd1 : req_bus.angle_step;
            span_ff <= {ld_a1[31], ld_a1} - {ld_a0[31], ld_a0};
         end
         OP_DIVINIT: begin
            bneg_ff <= prod_ff[PROD_W-1];
            dq_ff   <= prod_mag;
            rem_ff  <= '0;
         end
         OP_DIV: begin
            if (!div_trial[34])
               rem_ff <= div_trial[32:0];
            else
               rem_ff <= div_shift[32:0];
            dq_ff <= {dq_ff[62:0], !div_trial[34]};
         end
         OP_DIVEND: begin
            bstep_ff <= bneg_ff ? -$signed(qt) : $signed(qt);
            k_ff     <= '0;
            off_ff   <= '0;
            shacc_ff <= SH_W'(b0_ff);
         end
         OP_ANGLE: begin
            ang_ff <= cmd.end_pair ? a1_ff : a0_ff + $signed(off_ff[31:0]);
         end
         OP_XLAT: begin
            quad_ff <= prod_ff[55:54];
            x_ff    <= prod_ff[53:24];
            arg_ff  <= {1'b0, prod_ff[53:24]};
         end
         OP_ARGB: arg_ff <= Q30_ONE - {1'b0, x_ff};
         OP_X2: begin
            x2_ff <= prod_ff[60:30];
            p_ff  <= sin_coef(HORNER_SEED);
         end
         OP_HSUB: p_ff <= sin_coef(cmd.coef_idx) - prod_ff[61:30];
         OP_SAVE: begin
            if (cmd.half_b)
               sb_ff <= prod_ff[61:30];
            else
               sa_ff <= prod_ff[61:30];
         end
         OP_TRIG: begin
            sin_ff  <= quad_ff[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
            cos_ff  <= (^quad_ff) ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
            s15_ff  <= to_q15(smag);
            c15_ff  <= to_q15(cmag);
            sneg_ff <= quad_ff[1];
            cneg_ff <= ^quad_ff;
         end
         OP_PX: px_ff <= pos_sat(prod_ff, cx_ff);
         OP_PY: py_ff <= pos_sat(prod_ff, cy_ff);
         OP_EMIT: begin
            opx_ff    <= px_ff;
            opy_ff    <= py_ff;
            oacx_ff   <= signed16(rev_ff ^ cneg_ff, c15_ff);
            oacy_ff   <= signed16(rev_ff ^ sneg_ff, s15_ff);
            oalx_ff   <= signed16(rev_ff ^ sneg_ff, s15_ff);
            oaly_ff   <= signed16(!(rev_ff ^ cneg_ff), c15_ff);
            oside_ff  <= rev_ff ^ cmd.outer;
            oshade_ff <= cmd.end_pair ? b1_ff : sh_sat;
            olast_ff  <= cmd.end_pair & cmd.outer;
         end
         OP_NEXT: begin
            k_ff     <= k_ff + 1'b1;
            off_ff   <= off_ff + OFF_W'(step_ff);
            shacc_ff <= shacc_ff + SH_W'(bstep_ff);
         end
         default: ;
      endcase
   end

   // output valid
   always_comb begin
      ovalid_in = ovalid_ff;
      if (rsp_bus.ready)
         ovalid_in = 1'b0;
      if (cmd.op == OP_EMIT)
         ovalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         ovalid_ff <= 1'b0;
      else
         ovalid_ff <= ovalid_in;
   end

   assign status.req_valid  = req_bus.valid;
   assign status.out_free   = !ovalid_ff || rsp_bus.ready;
   assign status.more_pairs = (k_ff < CNT_W'(MAX_STEPS)) &&
                              (CMP_W'(off_ff) < CMP_W'(span_ff));

   assign req_bus.ready         = cmd.req_ready;
   assign rsp_bus.valid         = ovalid_ff;
   assign rsp_bus.pos_x         = opx_ff;
   assign rsp_bus.pos_y         = opy_ff;
   assign rsp_bus.across_x      = oacx_ff;
   assign rsp_bus.across_y      = oacy_ff;
   assign rsp_bus.along_x       = oalx_ff;
   assign rsp_bus.along_y       = oaly_ff;
   assign rsp_bus.side_positive = oside_ff;
   assign rsp_bus.shade         = oshade_ff;
   assign rsp_bus.last          = olast_ff;

endmodule

`default_nettype wire

>>> src/tasg_ctrl.sv
// ============================================================================
// tasg_ctrl
// Sequencer: shade division, per-angle sine evaluation, vertex emission.
// ============================================================================
`default_nettype none

module tasg_ctrl
   import tasg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       half_b_ff, half_b_in;
   logic       outer_ff, outer_in;
   logic       end_ff, end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         half_b_ff <= 1'b0;
         outer_ff  <= 1'b0;
         end_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         half_b_ff <= half_b_in;
         outer_ff  <= outer_in;
         end_ff    <= end_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      half_b_in = half_b_ff;
      outer_in  = outer_ff;
      end_in    = end_ff;
      unique case (state_ff)
         ST_IDLE:    if (status.req_valid) state_in = ST_BMUL;
         ST_BMUL:    state_in = ST_DIVINIT;
         ST_DIVINIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST)
               state_in = ST_DIVEND;
         end
         ST_DIVEND:  state_in = ST_CHECK;
         ST_CHECK: begin
            end_in   = !status.more_pairs;
            state_in = ST_PHASE;
         end
         ST_PHASE:   state_in = ST_XLAT;
         ST_XLAT: begin
            half_b_in = 1'b0;
            state_in  = ST_SQ;
         end
         ST_ARGB:    state_in = ST_SQ;
         ST_SQ:      state_in = ST_X2;
         ST_X2: begin
            cnt_in   = {3'b000, HORNER_TOP};
            state_in = ST_HMUL;
         end
         ST_HMUL:    state_in = ST_HSUB;
         ST_HSUB: begin
            if (cnt_ff == '0)
               state_in = ST_FMUL;
            else begin
               cnt_in   = cnt_ff - 6'd1;
               state_in = ST_HMUL;
            end
         end
         ST_FMUL:    state_in = ST_SAVE;
         ST_SAVE: begin
            if (!half_b_ff) begin
               half_b_in = 1'b1;
               state_in  = ST_ARGB;
            end else
               state_in  = ST_TRIG;
         end
         ST_TRIG: begin
            outer_in = 1'b0;
            state_in = ST_PMX;
         end
         ST_PMX:     state_in = ST_PX;
         ST_PX:      state_in = ST_PMY;
         ST_PMY:     state_in = ST_PY;
         ST_PY:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               if (!outer_ff) begin
                  outer_in = 1'b1;
                  state_in = ST_PMX;
               end else if (end_ff)
                  state_in = ST_IDLE;
               else
                  state_in = ST_NEXT;
            end
         end
         ST_NEXT:    state_in = ST_CHECK;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op        = OP_NONE;
      cmd.coef_idx  = cnt_ff[2:0];
      cmd.half_b    = half_b_ff;
      cmd.outer     = outer_ff;
      cmd.end_pair  = end_ff;
      cmd.req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid)
               cmd.op = OP_LOAD;
         end
         ST_BMUL:    cmd.op = OP_MUL_B;
         ST_DIVINIT: cmd.op = OP_DIVINIT;
         ST_DIV:     cmd.op = OP_DIV;
         ST_DIVEND:  cmd.op = OP_DIVEND;
         ST_CHECK: begin
            cmd.op       = OP_ANGLE;
            cmd.end_pair = !status.more_pairs;
         end
         ST_PHASE:   cmd.op = OP_PHASE;
         ST_XLAT:    cmd.op = OP_XLAT;
         ST_ARGB:    cmd.op = OP_ARGB;
         ST_SQ:      cmd.op = OP_SQ;
         ST_X2:      cmd.op = OP_X2;
         ST_HMUL:    cmd.op = OP_HMUL;
         ST_HSUB:    cmd.op = OP_HSUB;
         ST_FMUL:    cmd.op = OP_FMUL;
         ST_SAVE:    cmd.op = OP_SAVE;
         ST_TRIG:    cmd.op = OP_TRIG;
         ST_PMX:     cmd.op = OP_PMX;
         ST_PX:      cmd.op = OP_PX;
         ST_PMY:     cmd.op = OP_PMY;
         ST_PY:      cmd.op = OP_PY;
         ST_EMIT:    if (status.out_free) cmd.op = OP_EMIT;
         ST_NEXT:    cmd.op = OP_NEXT;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

>>> src/thick_arc_strip_generator.sv
// ============================================================================
// thick_arc_strip_generator
// Turns one arc request into the vertex stream of a triangle strip.
// ============================================================================
// Usage:
//   req_bus carries one arc per request (valid/ready). rsp_bus returns the
//   strip vertices in order, inner then outer per angle, with last set on
//   the outer vertex at the end angle. A request yields 2*(n+1) vertices,
//   n = stepped pairs, at most MAX_STEPS.
//   One request is worked at a time. req_bus.ready is high only while idle.
//   Setup forms the shade step product and runs a 64-bit restoring divider;
//   then each angle runs two Horner evaluations of the quarter-wave sine
//   through the one shared 33x33 multiplier.
//   A vertex sits in the output register until taken; a stalled receiver
//   holds the sequencer in its emit step, nothing is dropped. The next
//   request is accepted while the final vertex still waits.
//   Reset (synchronous, active high) returns the sequencer to idle and
//   empties the output register.
// ============================================================================
`default_nettype none

module thick_arc_strip_generator
   import tasg_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tasg_req_if.sink   req_bus,
   tasg_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   tasg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // arithmetic and output register
   tasg_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
